// ===== hdl/aes_pkg.sv =====
// Shared types, constants and round functions for the AES-128 engine.
package aes_pkg;

  localparam int unsigned RkDepth = 11;
  localparam int unsigned RkIdxW  = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_KEY_UPPER = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOWER = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  typedef struct packed {
    logic                key_start;
    logic                key_step;
    logic                load;
    logic                round_step;
    logic                last_round;
    logic                dec;
    logic [RkIdxW-1:0]   rk_addr;
    logic                rk_read;
    logic                out_load;
  } aes_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // Byte k of a block sits in bits 127-8k down to 120-8k.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned k);
    get_byte = s[127-8*k -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [127:0] byte_subst(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      r[127-8*k -: 8] = inv ? INV_SBOX[get_byte(s, k)] : SBOX[get_byte(s, k)];
    end
    byte_subst = r;
  endfunction

  function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        if (inv) begin
          r[127-8*(4*((c+w)%4)+w) -: 8] = get_byte(s, 4*c+w);
        end else begin
          r[127-8*(4*c+w) -: 8] = get_byte(s, 4*((c+w)%4)+w);
        end
      end
    end
    row_rotate = r;
  endfunction

  function automatic logic [127:0] col_mix(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   p0, p1, p2, p3, a;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      p0 = get_byte(s, 4*c);
      p1 = get_byte(s, 4*c+1);
      p2 = get_byte(s, 4*c+2);
      p3 = get_byte(s, 4*c+3);
      a  = p0 ^ p1 ^ p2 ^ p3;
      r[127-32*c -: 32] = {p0 ^ a ^ xtime(p0 ^ p1), p1 ^ a ^ xtime(p1 ^ p2),
                           p2 ^ a ^ xtime(p2 ^ p3), p3 ^ a ^ xtime(p3 ^ p0)};
    end
    col_mix = r;
  endfunction

  function automatic logic [127:0] col_unmix(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   e, o;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      e = xtime(xtime(get_byte(s, 4*c) ^ get_byte(s, 4*c+2)));
      o = xtime(xtime(get_byte(s, 4*c+1) ^ get_byte(s, 4*c+3)));
      r[127-32*c -: 32] = s[127-32*c -: 32] ^ {e, o, e, o};
    end
    col_unmix = col_mix(r);
  endfunction

endpackage

// ===== hdl/aes_ctrl.sv =====
// Sequencing state machine for key expansion and the cipher rounds.
module aes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_func,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              key_write,
  output aes_pkg::aes_cmd_t cmd
);
  import aes_pkg::*;

  aes_state_t        state_r, state_nxt;
  logic [RkIdxW-1:0] cnt_r, cnt_nxt;
  logic              keys_ready_r, keys_ready_nxt;
  logic              dec_r, dec_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      dec_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      keys_ready_r <= keys_ready_nxt;
      dec_r        <= dec_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = keys_ready_r ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (cnt_r == RkIdxW'(RkDepth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (cnt_r == RkIdxW'(RkDepth - 2)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // The state register is loaded at ST_LOAD with round key 0 (or 10) added; each
  // ST_ROUND cycle applies one round, the round key having been read in the cycle before.
  always_comb begin
    cmd            = '0;
    cmd.dec        = dec_r;
    cnt_nxt        = cnt_r;
    keys_ready_nxt = keys_ready_r;
    dec_nxt        = dec_r;
    out_valid_nxt  = out_valid_r;
    in_tready      = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          dec_nxt = in_func;
          if (keys_ready_r) begin
            cmd.rk_read = 1'b1;
            cmd.rk_addr = in_func ? RkIdxW'(RkDepth - 1) : '0;
          end else begin
            cmd.key_start = 1'b1;
          end
        end
      end
      ST_EXPAND: begin
        cmd.key_step = 1'b1;
        cmd.rk_addr  = cnt_r;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == RkIdxW'(RkDepth - 1)) begin
          keys_ready_nxt = 1'b1;
          cnt_nxt        = '0;
        end
      end
      ST_LOAD: begin
        in_tready   = 1'b1;
        cmd.load    = 1'b1;
        cmd.rk_read = 1'b1;
        cmd.rk_addr = dec_r ? RkIdxW'(RkDepth - 2) : RkIdxW'(1);
        cnt_nxt     = '0;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.last_round = (cnt_r == RkIdxW'(RkDepth - 2));
        cmd.rk_read    = !cmd.last_round;
        cmd.rk_addr    = dec_r ? RkIdxW'(RkDepth - 3) - cnt_r : cnt_r + RkIdxW'(2);
        cnt_nxt        = cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    if (key_write) begin
      keys_ready_nxt = 1'b0;
    end
  end

  // ST_DONE waits until the previous result has left the output register.
  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/aes_dp.sv =====
// Round key store, key expansion and round datapath.
module aes_dp (
  input  logic              clk,
  input  aes_pkg::aes_cmd_t cmd,
  input  logic [127:0]      key,
  input  logic [127:0]      block,
  output logic [127:0]      result
);
  import aes_pkg::*;

  logic [127:0] rk_mem [RkDepth];
  logic [127:0] rk_q_r;
  logic [127:0] ek_r, ek_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] res_r;
  logic [31:0]  w0, w1, w2, w3, t;
  logic [127:0] fwd, inv;

  always_comb begin
    t  = ek_r[31:0];
    t  = {SBOX[t[23:16]] ^ rcon_r, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
    w0 = ek_r[127:96] ^ t;
    w1 = ek_r[95:64] ^ w0;
    w2 = ek_r[63:32] ^ w1;
    w3 = ek_r[31:0] ^ w2;
    ek_nxt   = ek_r;
    rcon_nxt = rcon_r;
    if (cmd.key_start) begin
      ek_nxt   = key;
      rcon_nxt = 8'h01;
    end else if (cmd.key_step) begin
      ek_nxt   = {w0, w1, w2, w3};
      rcon_nxt = xtime(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    ek_r   <= ek_nxt;
    rcon_r <= rcon_nxt;
    if (cmd.key_step) begin
      rk_mem[cmd.rk_addr] <= ek_r;
    end
    if (cmd.rk_read) begin
      rk_q_r <= rk_mem[cmd.rk_addr];
    end
  end

  always_comb begin
    fwd = row_rotate(byte_subst(st_r, 1'b0), 1'b0);
    if (!cmd.last_round) begin
      fwd = col_mix(fwd);
    end
    fwd = fwd ^ rk_q_r;
    inv = byte_subst(row_rotate(st_r, 1'b1), 1'b1) ^ rk_q_r;
    if (!cmd.last_round) begin
      inv = col_unmix(inv);
    end
    st_nxt = st_r;
    if (cmd.load) begin
      st_nxt = block ^ rk_q_r;
    end else if (cmd.round_step) begin
      st_nxt = cmd.dec ? inv : fwd;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (cmd.out_load) begin
      res_r <= st_r;
    end
  end

  assign result = res_r;

endmodule

// ===== hdl/aes128_block_cipher_unit.sv =====
// Top level of the AES-128 ECB engine.
//
// The key is written over the cfg_ channel: index 0 holds key bytes 0 to 7 and
// index 1 key bytes 8 to 15, byte 0 most significant. Keys must be written only
// while the engine is idle, which the block itself does not enforce. A block
// beat on the in_ channel carries the direction in tuser (0 encrypt, 1 decrypt)
// and the 128-bit block in tdata. The result beat leaves on the out_ channel.
// A block passes from the cycle tvalid is seen to the result being valid through
// one round key read, the initial key addition, ten rounds at one round per
// cycle and the move into the output register. Blocks follow one at a time,
// paced by the single round unit and the round key memory port.
// The first block after reset or after a key write first expands the key,
// one round key per cycle, before the block itself is loaded.
// Reset clears the control state and marks the key as not yet expanded.
// The input beat is taken when the rounds begin; while a result waits on a
// stalled receiver the next block is taken and processed, and held back only
// at its final cycle until the earlier result has gone.
module aes128_block_cipher_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [127:0]                in_tdata,   // block_lower, block_upper
  input  logic                        in_tuser,   // func
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [127:0]                out_tdata,  // out_lower, out_upper
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);
  import aes_pkg::*;

  logic [63:0]  key_upper_r, key_lower_r;
  logic         key_write;
  aes_cmd_t     cmd;
  logic [127:0] result;

  assign cfg_ready = 1'b1;
  assign key_write = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_UPPER: key_upper_r <= cfg_data;
        CFG_KEY_LOWER: key_lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .key_write  (key_write),
    .cmd        (cmd)
  );

  aes_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .key    ({key_upper_r, key_lower_r}),
    .block  ({in_tdata[63:0], in_tdata[127:64]}),
    .result (result)
  );

  assign out_tdata = {result[63:0], result[127:64]};

endmodule

// ===== tb/aes128_block_cipher_unit_tb.sv =====
// Self-checking testbench for the AES-128 ECB engine: key changes, directed vectors, random blocks.
module aes128_block_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } block_t;

  typedef struct {
    logic        is_key;
    logic        decrypt;
    logic [63:0] upper;
    logic [63:0] lower;
    logic        typed;
    logic [63:0] want_upper;
    logic [63:0] want_lower;
  } vector_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [127:0]        in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [127:0]        out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [63:0]         cfg_data;

  logic [7:0]  fwd_box [256];
  logic [7:0]  rev_box [256];
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  block_t      pending_blocks [$];
  int unsigned mismatches;
  int unsigned blocks_sent;
  int unsigned blocks_checked;
  int unsigned key_writes;
  bit          quiet;
  int unsigned stall_left;

  aes128_block_cipher_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic logic [7:0] gf_twice(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = gf_twice(x);
    end
    return acc;
  endfunction

  function automatic block_t aes_transform(input logic decrypt, input logic [63:0] kh,
                                           input logic [63:0] kl, input logic [63:0] bh,
                                           input logic [63:0] bl);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    logic [7:0]  s [16];
    logic [7:0]  u [16];
    logic [7:0]  a0, a1, a2, a3;
    block_t      res;
    rc = 8'h01;
    w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gf_twice(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int k = 0; k < 8; k++) begin
      s[k] = bh[63-8*k -: 8];
      s[8+k] = bl[63-8*k -: 8];
    end
    for (int step = 0; step <= 10; step++) begin
      int rnd;
      rnd = decrypt ? 10 - step : step;
      if (decrypt && step > 0 && step < 10) begin
        for (int k = 0; k < 16; k++) s[k] ^= w[4*rnd + k/4][31-8*(k%4) -: 8];
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0,8'd14) ^ gf_mul(a1,8'd11) ^ gf_mul(a2,8'd13) ^ gf_mul(a3,8'd9);
          s[4*c+1] = gf_mul(a1,8'd14) ^ gf_mul(a2,8'd11) ^ gf_mul(a3,8'd13) ^ gf_mul(a0,8'd9);
          s[4*c+2] = gf_mul(a2,8'd14) ^ gf_mul(a3,8'd11) ^ gf_mul(a0,8'd13) ^ gf_mul(a1,8'd9);
          s[4*c+3] = gf_mul(a3,8'd14) ^ gf_mul(a0,8'd11) ^ gf_mul(a1,8'd13) ^ gf_mul(a2,8'd9);
        end
      end else if (!decrypt && step > 0) begin
        for (int k = 0; k < 16; k++) u[k] = fwd_box[s[4*((k/4 + k%4) % 4) + k%4]];
        s = u;
        if (step < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gf_twice(a0) ^ gf_mul(a1,8'd3) ^ a2 ^ a3;
            s[4*c+1] = gf_twice(a1) ^ gf_mul(a2,8'd3) ^ a3 ^ a0;
            s[4*c+2] = gf_twice(a2) ^ gf_mul(a3,8'd3) ^ a0 ^ a1;
            s[4*c+3] = gf_twice(a3) ^ gf_mul(a0,8'd3) ^ a1 ^ a2;
          end
        end
      end
      if (!(decrypt && step > 0 && step < 10)) begin
        for (int k = 0; k < 16; k++) s[k] ^= w[4*rnd + k/4][31-8*(k%4) -: 8];
      end
      if (decrypt && step < 10) begin
        for (int k = 0; k < 16; k++) u[4*((k/4 + k%4) % 4) + k%4] = rev_box[s[k]];
        s = u;
      end
    end
    for (int k = 0; k < 8; k++) begin
      res.upper[63-8*k -: 8] = s[k];
      res.lower[63-8*k -: 8] = s[8+k];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic write_key_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_UPPER) key_hi = value;
    else key_lo = value;
    key_writes++;
  endtask

  task automatic drain_results();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_block(input logic decrypt, input logic [63:0] bh, input logic [63:0] bl,
                            input logic typed, input logic [63:0] wh, input logic [63:0] wl);
    block_t want;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= decrypt;
    in_tdata  <= {bl, bh};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    want = aes_transform(decrypt, key_hi, key_lo, bh, bl);
    if (typed && want.upper != wh) report_mismatch("known answer upper", want.upper, wh);
    if (typed && want.lower != wl) report_mismatch("known answer lower", want.lower, wl);
    pending_blocks.push_back(want);
    blocks_sent++;
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata[63:0], 64'h0);
      end else begin
        want = pending_blocks.pop_front();
        if (out_tdata[63:0] !== want.upper)
          report_mismatch("out_upper", out_tdata[63:0], want.upper);
        if (out_tdata[127:64] !== want.lower)
          report_mismatch("out_lower", out_tdata[127:64], want.lower);
        blocks_checked++;
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("FAIL aes128_block_cipher_unit");
    $finish;
  end

  initial begin
    vector_t     vectors [$];
    logic [7:0]  inv;
    logic [7:0]  b;
    logic [63:0] kh;
    logic [63:0] kl;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KEY_UPPER;
    cfg_data = '0;
    key_hi = '0;
    key_lo = '0;
    mismatches = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    key_writes = 0;
    quiet = 1'b0;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_box[x] = b;
      rev_box[b] = 8'(x);
    end

    vectors = '{
      '{0, 0, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{0, 1, 64'h0, 64'h0, 0, 0, 0},
      '{0, 0, '1, '1, 0, 0, 0},
      '{0, 1, '1, '1, 0, 0, 0},
      '{1, 0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0, 0},
      '{0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{0, 1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{1, 0, '1, '1, 0, 0, 0},
      '{0, 0, 64'h0, 64'h0, 0, 0, 0},
      '{0, 1, '1, '1, 0, 0, 0},
      '{0, 0, 64'h8000000000000000, 64'h0000000000000001, 0, 0, 0},
      '{0, 1, 64'h8000000000000000, 64'h0000000000000001, 0, 0, 0},
      '{1, 0, 64'h0, 64'h0, 0, 0, 0},
      '{0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].is_key) begin
        in_tvalid <= 1'b0;
        drain_results();
        write_key_reg(CFG_KEY_UPPER, vectors[i].upper);
        write_key_reg(CFG_KEY_LOWER, vectors[i].lower);
      end else begin
        send_block(vectors[i].decrypt, vectors[i].upper, vectors[i].lower,
                   vectors[i].typed, vectors[i].want_upper, vectors[i].want_lower);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      in_tvalid <= 1'b0;
      drain_results();
      kh = (phase == 0) ? 64'h0 : (phase == 1) ? '1 : {$urandom, $urandom};
      kl = (phase == 0) ? 64'h0 : (phase == 1) ? '1 : {$urandom, $urandom};
      if (phase == 3) begin
        write_key_reg(CFG_KEY_LOWER, kl);
      end else if (phase == 4) begin
        write_key_reg(CFG_KEY_UPPER, kh);
      end else begin
        write_key_reg(CFG_KEY_UPPER, kh);
        write_key_reg(CFG_KEY_LOWER, kl);
      end
      quiet = (phase == 5);
      repeat (200) send_block(1'($urandom_range(0, 1)), random_word(), random_word(), 0, 0, 0);
    end
    in_tvalid <= 1'b0;
    drain_results();

    $display("covered %0d blocks in both directions, %0d checked, over %0d key writes",
             blocks_sent, blocks_checked, key_writes);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS aes128_block_cipher_unit");
    end else begin
      $display("FAIL aes128_block_cipher_unit");
    end
    $finish;
  end

endmodule
